### rtl/core/prq_pkg.sv
// Shared types and constants for the priority ready queue.
// Used by priority_ready_queue; has no dependencies.
package prq_pkg;

  localparam int unsigned DefaultDepth = 128;

  localparam logic [1:0] StatusInserted  = 2'd0;
  localparam logic [1:0] StatusFull      = 2'd1;
  localparam logic [1:0] StatusExtracted = 2'd2;
  localparam logic [1:0] StatusEmpty     = 2'd3;

  localparam logic OpInsert  = 1'b0;
  localparam logic OpExtract = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [15:0] proc_id;
    logic [7:0]  prio;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] served_id;
    logic [7:0]  served_prio;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
  } entry_t;

endpackage

### rtl/core/prq_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module prq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/priority_ready_queue.sv
// Priority ready queue: sequencer around one entry RAM (prq_ram), plus result register.
// Depends on prq_pkg and prq_ram.
//
// An insert, a full insert or an empty extract goes straight to StFin and loads its result
// there once the output register is free. An extract first scans the entry RAM for the
// highest priority (oldest wins ties), then shifts the entries behind the winner down by
// one, then loads the result in StFin. Both passes go through the single read port of the
// entry RAM, one entry per cycle. The input is stalled from acceptance until the result
// is loaded. A new transaction is accepted while a finished result still waits on the
// output. No clearing pass after reset: only entries below the fill count are ever read.
module priority_ready_queue
  import prq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CntFull = CW'(DEPTH);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StShift = 4'b0100,
    StFin   = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          rvld_q, rvld_d;
  logic [AW-1:0] ridx_q, ridx_d;
  logic [AW-1:0] best_q, best_d;
  entry_t        bent_q, bent_d;
  out_t          res_q, res_d;
  out_t          out_q, out_d;
  logic          out_vld_q, out_vld_d;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  logic [$bits(entry_t)-1:0] rdata;
  entry_t        rd_ent;
  logic          rd_en;
  logic          in_acc;
  logic          out_load;

  prq_ram #(
    .Width($bits(entry_t)),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_ent   = entry_t'(rdata);
  assign raddr    = ptr_q[AW-1:0];
  assign rd_en    = ptr_q < cnt_q;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == StFin) && (!out_vld_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    rvld_d    = 1'b0;
    ridx_d    = ridx_q;
    best_d    = best_q;
    bent_d    = bent_q;
    res_d     = res_q;
    we        = 1'b0;
    waddr     = cnt_q[AW-1:0];
    wdata     = entry_t'{id: in_data_i.proc_id, prio: in_data_i.prio};
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          res_d   = '0;
          state_d = StFin;
          if (in_data_i.operation == OpInsert) begin
            if (cnt_q == CntFull) begin
              res_d.status = StatusFull;
            end else begin
              we           = 1'b1;
              cnt_d        = cnt_q + CW'(1);
              res_d.status = StatusInserted;
            end
          end else if (cnt_q == '0) begin
            res_d.status = StatusEmpty;
          end else begin
            ptr_d   = '0;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (rd_en) begin
          ptr_d  = ptr_q + CW'(1);
          rvld_d = 1'b1;
          ridx_d = ptr_q[AW-1:0];
        end
        if (rvld_q && (ridx_q == '0 || rd_ent.prio > bent_q.prio)) begin
          best_d = ridx_q;
          bent_d = rd_ent;
        end
        if (!rd_en && !rvld_q) begin
          ptr_d   = CW'(best_q) + CW'(1);
          state_d = StShift;
        end
      end
      StShift: begin
        if (rd_en) begin
          ptr_d  = ptr_q + CW'(1);
          rvld_d = 1'b1;
          ridx_d = ptr_q[AW-1:0];
        end
        if (rvld_q) begin
          we    = 1'b1;
          waddr = ridx_q - AW'(1);
          wdata = rd_ent;
        end
        if (!rd_en && !rvld_q) begin
          cnt_d   = cnt_q - CW'(1);
          res_d   = out_t'{status: StatusExtracted, served_id: bent_q.id,
                           served_prio: bent_q.prio};
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_load) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rvld_q    <= rvld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    ridx_q <= ridx_d;
    best_q <= best_d;
    bent_q <= bent_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("fill count above depth");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> !we)
    else $error("entry RAM written during scan");

  a_fin_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_vld_q && state_q == StIdle))
    else $error("finished result not presented");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.status != StatusExtracted) |->
      (out_q.served_id == '0 && out_q.served_prio == '0))
    else $error("served fields nonzero without extraction");
`endif

endmodule
